### rtl/core/battery_coulomb_gauge_defines.svh
// assertion macros for the battery coulomb gauge
// no dependencies; taken in by the files that carry assertions
`ifndef BATTERY_COULOMB_GAUGE_DEFINES_SVH
`define BATTERY_COULOMB_GAUGE_DEFINES_SVH

// same-cycle implication, checked on the rising edge of clk outside reset
`define BCG_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on the rising edge of clk outside reset
`define BCG_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/bcg_pkg.sv
// shared constants, types and state codes of the battery coulomb gauge
// no dependencies; used by bcg_mul, bcg_div and battery_coulomb_gauge
package bcg_pkg;

  // energy accumulator width (40 to 64)
  localparam int ENERGY_BITS = 48;

  // field widths
  localparam int RATED_W    = 20;
  localparam int THR_W      = 10;
  localparam int DRAW_W     = 10;
  localparam int CUR_W      = 16;
  localparam int VOLT_W     = 16;
  localparam int EVENT_W    = 3;
  localparam int SOC_W      = 7;
  localparam int HEALTH_W   = 8;
  localparam int CYCLE_W    = 32;
  localparam int OUT_E_W    = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 144;

  // energy units per mWh
  localparam int UNITS_W = 29;
  localparam logic [UNITS_W-1:0] UNITS_PER_MWH = 29'd360000000;
  localparam int DEN_W = RATED_W + UNITS_W;

  // per-tick energy: |x| * factor, then times voltage
  localparam int MAG_W   = 16;
  localparam int FACT_W  = 6;
  localparam int M_W     = 21;
  localparam int DELTA_W = M_W + VOLT_W;
  localparam logic [FACT_W-1:0] CHG_FACT = 6'd49;
  localparam logic [FACT_W-1:0] DIS_FACT = 6'd50;

  // serial multiplier and divider sizes
  localparam int PCT_W   = 7;
  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;
  localparam int PROD_W  = (ENERGY_BITS + PCT_W > DEN_W) ? ENERGY_BITS + PCT_W : DEN_W;
  localparam int MUL_A_W = ENERGY_BITS;
  localparam int MUL_B_W = RATED_W;
  localparam int STEP_W  = $clog2(MUL_B_W + 1);
  localparam int DIVD_W  = (ENERGY_BITS > DEN_W) ? ENERGY_BITS : DEN_W;
  localparam int QUOT_W  = 8;
  localparam int DCNT_W  = $clog2(QUOT_W + 1);

  localparam logic [STEP_W-1:0] STEPS_VOLT  = STEP_W'(VOLT_W);
  localparam logic [STEP_W-1:0] STEPS_PCT   = STEP_W'(PCT_W);
  localparam logic [STEP_W-1:0] STEPS_RATED = STEP_W'(RATED_W);

  // register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_RATED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW  = 2'd2;
  localparam logic [RATED_W-1:0] RATED_RESET = 20'd181300;
  localparam logic [THR_W-1:0]   THR_RESET   = 10'd13;
  localparam logic [DRAW_W-1:0]  DRAW_RESET  = 10'd20;

  // battery events that change state
  localparam logic [EVENT_W-1:0] EV_FULL  = 3'd1;
  localparam logic [EVENT_W-1:0] EV_EMPTY = 3'd2;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_MDELTA,
    S_ACC,
    S_PEAK,
    S_MPEAK,
    S_MDEN,
    S_DHEALTH,
    S_MSOC,
    S_DSOC,
    S_DONE
  } state_t;

  // multiplier launch control
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } mul_ctl_t;

endpackage

### rtl/core/battery_coulomb_gauge.sv
// Coulomb-counting fuel gauge: each accepted request is one 500 ms tick
// (current, voltage, event) and gives exactly one result (soc, health,
// cycle percent, remaining and peak energy before the event). One tick is
// worked on at a time; ready returns once its result has been loaded into
// the output register, and the done state holds while the previous result
// is not yet taken. A tick passes the prep, accumulate, peak and done states,
// the shared bit-serial multiplier (16, 7, 20 and 7 steps for the tick energy,
// 100 * peak, rated * 360000000 and 100 * remaining) and the serial divider
// (two runs of 8 steps for health and soc). A division whose quotient
// saturates (health at 255, or soc with a zero peak) ends right after its
// launch, without its serial steps. A new tick is taken while the previous
// result still waits on the output. Configuration writes are taken at any
// time and must only be made while no tick is in flight. Energy is in units
// of 1/360000000 mWh.
// depends on bcg_pkg, bcg_mul, bcg_div and battery_coulomb_gauge_defines.svh
module battery_coulomb_gauge (
  input  logic                                clk,
  input  logic                                rst,
  // tdata: current_ma [15:0], voltage_mv [31:16], battery_event [34:32]
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [bcg_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // tdata: soc_percent [6:0], health_percent [14:7], cycle_percent [46:15],
  //        energy_left [94:47], peak_energy [142:95]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [bcg_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bcg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bcg_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import bcg_pkg::*;
`include "battery_coulomb_gauge_defines.svh"

  state_t state, state_next;
  logic   launch;

  // configuration
  logic [RATED_W-1:0] rated;
  logic [THR_W-1:0]   thr;
  logic [DRAW_W-1:0]  draw;

  // captured request
  logic [CUR_W-1:0]   cur;
  logic [VOLT_W-1:0]  volt;
  logic [EVENT_W-1:0] event_code;

  // gauge state
  logic [ENERGY_BITS-1:0] acc;
  logic [ENERGY_BITS-1:0] peak;
  logic [CYCLE_W-1:0]     cycle;
  logic [SOC_W-1:0]       last_soc;

  // working registers
  logic [M_W-1:0]      m;
  logic                neg;
  logic [PROD_W-1:0]   npct;
  logic [HEALTH_W-1:0] health_pct;
  logic [SOC_W-1:0]    soc_pct;

  // shared units
  mul_ctl_t            mul_ctl;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic                mul_done;
  logic [PROD_W-1:0]   mul_prod;
  logic                div_start;
  logic [PROD_W-1:0]   div_num;
  logic [DIVD_W-1:0]   div_den;
  logic                div_done;
  logic [QUOT_W-1:0]   div_quot;

  // combinational datapath
  logic                    in_take;
  logic                    out_free;
  logic                    out_load;
  logic signed [CUR_W:0]   cur_x;
  logic signed [CUR_W:0]   thr_x;
  logic signed [CUR_W:0]   draw_x;
  logic signed [CUR_W:0]   x_val;
  logic signed [CUR_W:0]   mag_x;
  logic                    gt;
  logic                    lt;
  logic [FACT_W-1:0]       fact;
  logic [MAG_W+FACT_W-1:0] mf;
  logic [DELTA_W-1:0]      delta;
  logic [ENERGY_BITS:0]    sum;
  logic [ENERGY_BITS:0]    diff;
  logic [ENERGY_BITS-1:0]  acc_new;
  logic [CYCLE_W-1:0]      cycle_new;

  bcg_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mul_ctl),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_prod)
  );

  bcg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_take   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign cfg_ready = 1'b1;

  // tick energy operand: sign and |x| * factor
  assign cur_x  = {cur[CUR_W-1], cur};
  assign thr_x  = {{(CUR_W + 1 - THR_W){1'b0}}, thr};
  assign draw_x = {{(CUR_W + 1 - DRAW_W){1'b0}}, draw};
  assign gt     = cur_x > thr_x;
  assign lt     = cur_x < thr_x;
  assign x_val  = gt ? cur_x : (lt ? cur_x - draw_x : -draw_x);
  assign mag_x  = x_val[CUR_W] ? -x_val : x_val;
  assign fact   = gt ? CHG_FACT : DIS_FACT;
  assign mf     = (MAG_W + FACT_W)'(mag_x[MAG_W-1:0]) * (MAG_W + FACT_W)'(fact);

  // accumulate with clamp at zero and saturation at the top
  assign delta   = mul_prod[DELTA_W-1:0];
  assign sum     = {1'b0, acc} + (ENERGY_BITS + 1)'(delta);
  assign diff    = {1'b0, acc} - (ENERGY_BITS + 1)'(delta);
  assign acc_new = neg ? (diff[ENERGY_BITS] ? '0 : diff[ENERGY_BITS-1:0])
                       : (sum[ENERGY_BITS] ? '1 : sum[ENERGY_BITS-1:0]);

  // soc drops add to the cycle count
  assign cycle_new = (soc_pct < last_soc) ? cycle + CYCLE_W'(last_soc - soc_pct) : cycle;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (s_axis_tvalid) state_next = S_PREP;
      S_PREP:    state_next = S_MDELTA;
      S_MDELTA:  if (mul_done) state_next = S_ACC;
      S_ACC:     state_next = S_PEAK;
      S_PEAK:    state_next = S_MPEAK;
      S_MPEAK:   if (mul_done) state_next = S_MDEN;
      S_MDEN:    if (mul_done) state_next = S_DHEALTH;
      S_DHEALTH: if (div_done) state_next = S_MSOC;
      S_MSOC:    if (mul_done) state_next = S_DSOC;
      S_DSOC:    if (div_done) state_next = S_DONE;
      S_DONE:    if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // sequencer outputs and unit operands
  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    mul_ctl       = '0;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;
    div_num       = '0;
    div_den       = '0;
    case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
      end
      S_MDELTA: begin
        mul_ctl.start = launch;
        mul_ctl.steps = STEPS_VOLT;
        mul_a         = MUL_A_W'(m);
        mul_b         = MUL_B_W'(volt);
      end
      S_MPEAK: begin
        mul_ctl.start = launch;
        mul_ctl.steps = STEPS_PCT;
        mul_a         = MUL_A_W'(peak);
        mul_b         = MUL_B_W'(PCT_SCALE);
      end
      S_MDEN: begin
        mul_ctl.start = launch;
        mul_ctl.steps = STEPS_RATED;
        mul_a         = MUL_A_W'(UNITS_PER_MWH);
        mul_b         = rated;
      end
      S_DHEALTH: begin
        div_start = launch;
        div_num   = npct;
        div_den   = DIVD_W'(mul_prod);
      end
      S_MSOC: begin
        mul_ctl.start = launch;
        mul_ctl.steps = STEPS_PCT;
        mul_a         = MUL_A_W'(acc);
        mul_b         = MUL_B_W'(PCT_SCALE);
      end
      S_DSOC: begin
        div_start = launch;
        div_num   = mul_prod;
        div_den   = DIVD_W'(peak);
      end
      S_DONE: begin
        out_load = out_free;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // state register; launch marks the first cycle in a state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      launch <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= (state_next != state);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rated <= RATED_RESET;
      thr   <= THR_RESET;
      draw  <= DRAW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RATED: rated <= cfg_data;
        REG_THR:   thr   <= cfg_data[THR_W-1:0];
        REG_DRAW:  draw  <= cfg_data[DRAW_W-1:0];
        default:   rated <= rated;
      endcase
    end
  end

  // request capture and working registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      cur        <= s_axis_tdata[CUR_W-1:0];
      volt       <= s_axis_tdata[CUR_W+VOLT_W-1:CUR_W];
      event_code <= s_axis_tdata[CUR_W+VOLT_W+EVENT_W-1:CUR_W+VOLT_W];
    end
    if (state == S_PREP) begin
      m   <= mf[M_W-1:0];
      neg <= x_val[CUR_W];
    end
    if (state == S_MPEAK && mul_done) begin
      npct <= mul_prod;
    end
    if (state == S_DHEALTH && div_done) begin
      health_pct <= div_quot;
    end
    if (state == S_DSOC && div_done) begin
      soc_pct <= (peak == '0) ? '0 : div_quot[SOC_W-1:0];
    end
  end

  // gauge state: energy, peak, cycle count, previous soc, events
  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      peak     <= '0;
      cycle    <= '0;
      last_soc <= '0;
    end else begin
      if (state == S_ACC) begin
        acc <= acc_new;
      end
      if (state == S_PEAK && acc > peak) begin
        peak <= acc;
      end
      if (out_load) begin
        cycle    <= cycle_new;
        last_soc <= soc_pct;
        if (event_code == EV_FULL) begin
          peak <= acc;
        end else if (event_code == EV_EMPTY) begin
          acc <= '0;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {1'b0, OUT_E_W'(peak), OUT_E_W'(acc), cycle_new,
                       health_pct, soc_pct};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // checks
  `BCG_ASSERT_NXT(a_take_starts, in_take, state == S_PREP, "accepted tick did not start")
  `BCG_ASSERT_IMP(a_peak_bound, state == S_IDLE, acc <= peak, "remaining above peak at idle")
  `BCG_ASSERT_IMP(a_soc_range, m_axis_tvalid, m_axis_tdata[SOC_W-1:0] <= PCT_SCALE,
                  "soc above 100")
  `BCG_ASSERT_IMP(a_mul_owner, mul_done,
                  state == S_MDELTA || state == S_MPEAK || state == S_MDEN || state == S_MSOC,
                  "multiplier finished outside a multiply step")

endmodule

### rtl/core/bcg_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle, lsb first
// depends on bcg_pkg
module bcg_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  bcg_pkg::mul_ctl_t             ctl,
  input  logic [bcg_pkg::MUL_A_W-1:0]   a,
  input  logic [bcg_pkg::MUL_B_W-1:0]   b,
  output logic                          done,
  output logic [bcg_pkg::PROD_W-1:0]    prod
);
  import bcg_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [PROD_W-1:0] a_sh;
  logic [MUL_B_W-1:0] b_sh;

  // step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= ctl.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift-add datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_sh <= PROD_W'(a);
      b_sh <= b;
      prod <= '0;
    end else if (busy) begin
      if (b_sh[0]) begin
        prod <= prod + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

endmodule

### rtl/core/bcg_div.sv
// restoring divider giving an 8 bit quotient, one quotient bit per cycle
// saturates to all ones when the quotient does not fit; depends on bcg_pkg
module bcg_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bcg_pkg::PROD_W-1:0]   num,
  input  logic [bcg_pkg::DIVD_W-1:0]   den,
  output logic                         done,
  output logic [bcg_pkg::QUOT_W-1:0]   quot
);
  import bcg_pkg::*;

  localparam int DW = DIVD_W + QUOT_W;

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [DW-1:0]     rem;
  logic [DW-1:0]     dsh;
  logic              ovf;
  logic              fits;

  // quotient would reach 2^QUOT_W
  assign ovf  = DW'(num) >= {den, {QUOT_W{1'b0}}};
  assign fits = rem >= dsh;

  // control: counter, busy and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= !ovf;
        done <= ovf;
        cnt  <= DCNT_W'(QUOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // trial subtract and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= DW'(num);
      dsh  <= DW'({den, {(QUOT_W - 1){1'b0}}});
      quot <= ovf ? '1 : '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quot <= {quot[QUOT_W-2:0], fits};
      dsh  <= dsh >> 1;
    end
  end

endmodule

### test/tb_battery_coulomb_gauge.sv
`timescale 1ns / 1ps
// testbench for battery_coulomb_gauge: ticks stream in, readings are checked
// against a cycle-free predictor of the gauge kept here; depends on bcg_pkg and battery_coulomb_gauge
module tb_battery_coulomb_gauge;
  import bcg_pkg::*;

  // battery event codes that leave the state alone
  localparam logic [EVENT_W-1:0] EV_NONE        = 3'd0;
  localparam logic [EVENT_W-1:0] EV_CHARGING    = 3'd3;
  localparam logic [EVENT_W-1:0] EV_DISCHARGING = 3'd4;
  localparam logic [EVENT_W-1:0] EV_SPARE5      = 3'd5;
  localparam logic [EVENT_W-1:0] EV_SPARE6      = 3'd6;
  localparam logic [EVENT_W-1:0] EV_SPARE7      = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 2'd3;

  localparam logic [127:0] ENERGY_TOP = (128'd1 << ENERGY_BITS) - 128'd1;
  localparam int RANDOM_TICKS = 950;
  localparam int RAMP_TICKS   = 300;
  localparam int MAX_PRINTS   = 40;

  typedef struct packed {
    logic signed [CUR_W-1:0] current;
    logic [VOLT_W-1:0]       voltage;
    logic [EVENT_W-1:0]      batt_event;
  } tick_t;

  typedef struct packed {
    logic [SOC_W-1:0]    soc;
    logic [HEALTH_W-1:0] health;
    logic [CYCLE_W-1:0]  cycle_pct;
    logic [OUT_E_W-1:0]  remaining;
    logic [OUT_E_W-1:0]  peak;
  } gauge_reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tick_t pending_ticks[$];
  gauge_reading_t expected_readings[$];
  int error_count = 0;
  int readings_seen = 0;
  bit sender_idles = 1'b0;
  bit receiver_stalls = 1'b0;

  // predicted gauge state and register copies
  logic [RATED_W-1:0]     rated_q;
  logic [THR_W-1:0]       charge_thr_q;
  logic [DRAW_W-1:0]      draw_q;
  logic [ENERGY_BITS-1:0] energy_q;
  logic [ENERGY_BITS-1:0] peak_q;
  logic [CYCLE_W-1:0]     cycle_q;
  logic [SOC_W-1:0]       last_soc_q;

  battery_coulomb_gauge dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // one tick of the gauge: energy update, peak, readings, then the event
  task automatic gauge_step(input logic signed [CUR_W-1:0] cur_ma,
                            input logic [VOLT_W-1:0] volt_mv,
                            input logic [EVENT_W-1:0] ev,
                            output gauge_reading_t res);
    longint signed cur, vol, thr, draw, delta;
    logic [127:0] sum, mag, den, h;
    logic [SOC_W-1:0] soc;
    logic [HEALTH_W-1:0] health;
    cur = longint'(cur_ma);
    vol = longint'(volt_mv);
    thr = longint'(charge_thr_q);
    draw = longint'(draw_q);
    if (cur > thr) begin
      delta = vol * cur * 49;
    end else if (cur < thr) begin
      delta = vol * (cur - draw) * 50;
    end else begin
      delta = -(vol * draw * 50);
    end
    // clamp at zero, saturate at the top
    if (delta >= 0) begin
      sum = 128'(energy_q) + 128'(delta);
      if (sum > ENERGY_TOP) sum = ENERGY_TOP;
    end else begin
      mag = 128'(-delta);
      if (mag >= 128'(energy_q)) sum = '0;
      else sum = 128'(energy_q) - mag;
    end
    energy_q = sum[ENERGY_BITS-1:0];
    if (energy_q > peak_q) peak_q = energy_q;
    if (rated_q == '0) begin
      health = 8'd255;
    end else begin
      den = 128'(rated_q) * 128'd360000000;
      h = (128'(peak_q) * 128'd100) / den;
      health = (h > 128'd255) ? 8'd255 : h[7:0];
    end
    if (peak_q == '0) soc = '0;
    else soc = 7'((128'(energy_q) * 128'd100) / 128'(peak_q));
    // soc drops add to the cycle count
    if (soc < last_soc_q) cycle_q = cycle_q + 32'(last_soc_q - soc);
    last_soc_q = soc;
    res.soc = soc;
    res.health = health;
    res.cycle_pct = cycle_q;
    res.remaining = OUT_E_W'(energy_q);
    res.peak = OUT_E_W'(peak_q);
    if (ev == EV_FULL) peak_q = energy_q;
    else if (ev == EV_EMPTY) energy_q = '0;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("mismatch in %s at reading %0d: got 0x%0h, expected 0x%0h",
               what, readings_seen, got, want);
  endtask

  // predictor: register writes and accepted ticks
  always @(posedge clk) begin : predict_proc
    gauge_reading_t res;
    if (rst) begin
      rated_q = RATED_RESET;
      charge_thr_q = THR_RESET;
      draw_q = DRAW_RESET;
      energy_q = '0;
      peak_q = '0;
      cycle_q = '0;
      last_soc_q = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RATED: rated_q = cfg_data[RATED_W-1:0];
          REG_THR:   charge_thr_q = cfg_data[THR_W-1:0];
          REG_DRAW:  draw_q = cfg_data[DRAW_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        gauge_step(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tdata[34:32], res);
        expected_readings.push_back(res);
      end
    end
  end

  // sender: ticks back to back, or bursts of ticks with random gaps while sender_idles is set
  always @(posedge clk) begin : send_proc
    tick_t nxt;
    logic drive_valid;
    int burst_left;
    int gap_left;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      drive_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_ticks.size() > 0) begin
        nxt = pending_ticks.pop_front();
        s_axis_tdata <= {5'b0, nxt.batt_event, nxt.voltage, nxt.current};
        drive_valid = 1'b1;
        if (sender_idles) begin
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 100)
                                                   : $urandom_range(0, 4);
          end
        end
      end
      s_axis_tvalid <= drive_valid;
    end
  end

  // receiver: always ready, or short ready runs broken by stalls of varied length while receiver_stalls is set
  always @(posedge clk) begin : recv_proc
    int run_left;
    int stall_left;
    if (rst) begin
      m_axis_tready <= 1'b0;
      run_left = 0;
      stall_left = 0;
    end else if (!receiver_stalls) begin
      m_axis_tready <= 1'b1;
    end else if (run_left > 0) begin
      run_left--;
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      run_left = $urandom_range(0, 6);
      stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120)
                                               : $urandom_range(0, 8);
      m_axis_tready <= 1'b1;
    end
  end

  // checker: each reading against the oldest prediction
  always @(posedge clk) begin : check_proc
    gauge_reading_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected reading", 64'(m_axis_tdata[46:0]), 64'd0);
      end else begin
        want = expected_readings.pop_front();
        if (m_axis_tdata[6:0] !== want.soc)
          report_mismatch("soc_percent", 64'(m_axis_tdata[6:0]), 64'(want.soc));
        if (m_axis_tdata[14:7] !== want.health)
          report_mismatch("health_percent", 64'(m_axis_tdata[14:7]), 64'(want.health));
        if (m_axis_tdata[46:15] !== want.cycle_pct)
          report_mismatch("cycle_percent", 64'(m_axis_tdata[46:15]), 64'(want.cycle_pct));
        if (m_axis_tdata[94:47] !== want.remaining)
          report_mismatch("energy_left", 64'(m_axis_tdata[94:47]),
                          64'(want.remaining));
        if (m_axis_tdata[142:95] !== want.peak)
          report_mismatch("peak_energy", 64'(m_axis_tdata[142:95]), 64'(want.peak));
      end
      readings_seen++;
    end
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

  // stimulus
  int cur_thr = int'(THR_RESET);
  int random_ticks = 0;

  task automatic queue_tick(input int cur, input int volt, input logic [EVENT_W-1:0] ev);
    tick_t t;
    t.current = 16'(cur);
    t.voltage = 16'(volt);
    t.batt_event = ev;
    pending_ticks.push_back(t);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] rated,
                            input logic [CFG_DATA_W-1:0] thr,
                            input logic [CFG_DATA_W-1:0] draw);
    write_reg(REG_RATED, rated);
    write_reg(REG_THR, thr);
    write_reg(REG_DRAW, draw);
    cur_thr = int'(thr[THR_W-1:0]);
  endtask

  // waits until the gauge has answered every tick; sampled between
  // edges so the queues and the valid line have settled
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || s_axis_tvalid || expected_readings.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // charge run, optional full, discharge run, optional empty
  task automatic queue_cycle();
    int n;
    int volt;
    n = $urandom_range(2, 20);
    for (int i = 0; i < n; i++) begin
      volt = $urandom_range(3000, 4400);
      queue_tick($urandom_range(cur_thr + 1, 6000), volt,
                 $urandom_range(0, 1) ? EV_CHARGING : EV_NONE);
    end
    if ($urandom_range(0, 9) < 7) queue_tick($urandom_range(cur_thr + 1, 600), 4200, EV_FULL);
    n = $urandom_range(2, 25);
    for (int i = 0; i < n; i++) begin
      volt = $urandom_range(3000, 4400);
      queue_tick(-$urandom_range(0, 6000), volt,
                 $urandom_range(0, 1) ? EV_DISCHARGING : EV_NONE);
    end
    if ($urandom_range(0, 9) < 7) queue_tick(-$urandom_range(0, 300), 3000, EV_EMPTY);
  endtask

  initial begin : stimulus_proc
    int phase_len;
    int start_len;
    int pick;
    logic [CFG_DATA_W-1:0] rated_v, thr_v, draw_v;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    // directed ticks under the reset register values
    queue_tick(0, 0, EV_NONE);
    queue_tick(32767, 65535, EV_NONE);
    queue_tick(13, 65535, EV_NONE);
    queue_tick(14, 1000, EV_CHARGING);
    queue_tick(12, 1000, EV_DISCHARGING);
    queue_tick(-32768, 65535, EV_NONE);
    queue_tick(1000, 4000, EV_NONE);
    queue_tick(1000, 4000, EV_NONE);
    queue_tick(1000, 4000, EV_NONE);
    queue_tick(1000, 4000, EV_FULL);
    queue_tick(-500, 4000, EV_NONE);
    queue_tick(-500, 4000, EV_NONE);
    queue_tick(-1, 65535, EV_DISCHARGING);
    queue_tick(0, 4000, EV_EMPTY);
    queue_tick(0, 0, EV_NONE);
    queue_tick(2000, 3700, EV_SPARE5);
    queue_tick(2000, 3700, EV_SPARE6);
    queue_tick(-2000, 3700, EV_SPARE7);
    queue_tick(2000, 3700, EV_FULL);
    queue_tick(-32768, 0, EV_NONE);
    queue_tick(32767, 4000, EV_NONE);
    queue_tick(-32768, 65535, EV_EMPTY);
    wait_quiet();

    // register extremes, including a write to the unused index
    set_config(20'd1, 20'd1023, 20'd1023);
    write_reg(REG_SPARE, 20'hFFFFF);
    sender_idles = 1'b1;
    receiver_stalls = 1'b1;
    queue_tick(1023, 4000, EV_NONE);
    queue_tick(1024, 4000, EV_NONE);
    queue_tick(1022, 4000, EV_NONE);
    repeat (6) queue_cycle();
    wait_quiet();

    // long run of maximum charge ticks, then maximum discharge
    set_config(20'd181300, 20'd13, 20'd20);
    sender_idles = 1'b0;
    receiver_stalls = 1'b0;
    for (int i = 0; i < RAMP_TICKS; i++)
      queue_tick(32767, 65535, $urandom_range(0, 1) ? EV_CHARGING : EV_NONE);
    queue_tick(-32768, 65535, EV_NONE);
    queue_tick(-32768, 65535, EV_FULL);
    queue_tick(32767, 65535, EV_NONE);
    wait_quiet();

    // random phases, each under its own register setting
    while (random_ticks < RANDOM_TICKS) begin
      case ($urandom_range(0, 5))
        0: rated_v = 20'd0;
        1: rated_v = 20'd1;
        2: rated_v = 20'd1000000;
        3: rated_v = 20'hFFFFF;
        4: rated_v = 20'($urandom_range(1, 300));
        default: rated_v = 20'($urandom_range(0, 20'hFFFFF));
      endcase
      pick = $urandom_range(0, 3);
      thr_v = (pick == 0) ? 20'd0 : (pick == 1) ? 20'd1023 :
              (pick == 2) ? 20'($urandom_range(0, 1023)) : 20'($urandom_range(0, 20'hFFFFF));
      pick = $urandom_range(0, 3);
      draw_v = (pick == 0) ? 20'd0 : (pick == 1) ? 20'd1023 :
               (pick == 2) ? 20'($urandom_range(0, 1023)) : 20'($urandom_range(0, 20'hFFFFF));
      set_config(rated_v, thr_v, draw_v);
      sender_idles = ($urandom_range(0, 3) != 0);
      receiver_stalls = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(120, 220);
      start_len = pending_ticks.size();
      while (pending_ticks.size() - start_len < phase_len) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          queue_tick($urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
                     3'($urandom_range(0, 7)));
        end else if (pick == 2) begin
          queue_tick(cur_thr + $urandom_range(0, 2) - 1, $urandom_range(0, 16'hFFFF),
                     3'($urandom_range(0, 7)));
        end else begin
          queue_cycle();
        end
      end
      random_ticks += pending_ticks.size() - start_len;
      wait_quiet();
    end

    repeat (100) @(posedge clk);
    if (expected_readings.size() != 0)
      report_mismatch("readings still awaited", 64'(expected_readings.size()), 64'd0);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/bcg_pkg.sv
rtl/core/bcg_mul.sv
rtl/core/bcg_div.sv
rtl/core/battery_coulomb_gauge.sv
test/tb_battery_coulomb_gauge.sv
